// ----- sv/rgbhls_pkg.sv -----
// Shared constants and types for the RGB to HLS converter.
// No dependencies; rgbhls_front, the top and the testbench refer to it by scoped names.
package rgbhls_pkg;

    localparam int CHANNEL_FRAC_BITS_DEF = 12;
    localparam int HUE_FRAC_BITS_DEF     = 6;

    localparam int IN_W    = 16;
    localparam int HUE_W   = 15;
    localparam int LS_W    = 13;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Hue constants in degrees and sector offsets in units of 60 degrees
    localparam int HUE_SECTOR_DEG = 60;
    localparam int HUE_TURN_DEG   = 360;
    localparam int HUE_MAX_DEG    = 420;
    localparam int OFS_RED        = 6;
    localparam int OFS_GREEN      = 2;
    localparam int OFS_BLUE       = 4;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

endpackage

// ----- sv/rgbhls_front.sv -----
// Front stages of the converter: clamp, max/min, sector, lightness and
// divider operands. Depends on rgbhls_pkg.
module rgbhls_front #(
    parameter int CF = rgbhls_pkg::CHANNEL_FRAC_BITS_DEF,
    parameter int HF = rgbhls_pkg::HUE_FRAC_BITS_DEF,
    parameter int CW = CF + 1,
    parameter int NW = 32,
    parameter int DW = CW + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rgbhls_pkg::IN_W-1:0]   red,
    input  logic [rgbhls_pkg::IN_W-1:0]   green,
    input  logic [rgbhls_pkg::IN_W-1:0]   blue,
    output logic                          out_valid,
    output logic [NW-1:0]                 hue_num,
    output logic [DW-1:0]                 hue_den,
    output logic [NW-1:0]                 sat_num,
    output logic [DW-1:0]                 sat_den,
    output logic [CW-1:0]                 light,
    output logic                          grey
);

    localparam int ONE    = 1 << CF;
    localparam int HSCALE = rgbhls_pkg::HUE_SECTOR_DEG << HF;
    localparam int HSW    = 6 + HF;
    localparam int BW     = CW + 3;

    function automatic logic [CW-1:0] clamp(input logic [rgbhls_pkg::IN_W-1:0] x);
        logic [CW-1:0] v;
        if (x[rgbhls_pkg::IN_W-1])
            v = '0;
        else if (int'(x[rgbhls_pkg::IN_W-2:0]) > ONE)
            v = CW'(ONE);
        else
            v = CW'(x[rgbhls_pkg::IN_W-2:0]);
        return v;
    endfunction

    // stage 1: clamped channels
    logic [3:0]    v_reg;
    logic [CW-1:0] r_reg, g_reg, b_reg;
    // stage 2: extremes and sector
    logic [CW-1:0] mx_reg, mn_reg;
    logic [CW:0]   ab_reg;
    rgbhls_pkg::sector_t sec_reg;
    // stage 3: difference, lightness, base, saturation denominator
    logic [CW-1:0] diff_reg, light3_reg;
    logic [BW-1:0] base_reg;
    logic [CW:0]   sden_reg;
    logic          grey3_reg;
    // stage 4: operands
    logic [NW-1:0] hnum_reg, snum_reg;
    logic [DW-1:0] hden_reg, sden4_reg;
    logic [CW-1:0] light4_reg;
    logic          grey4_reg;

    logic [CW-1:0] mx_next, mn_next;
    logic [CW:0]   ab_next;
    rgbhls_pkg::sector_t sec_next;
    logic [CW:0]   sum_s3;
    logic [CW-1:0] diff_s3;
    logic [BW-1:0] base_next;
    logic [BW+HSW-1:0] prod_s4;

    always_comb
    begin
        mx_next = r_reg;
        mn_next = r_reg;
        if (g_reg < mn_next) mn_next = g_reg;
        if (b_reg < mn_next) mn_next = b_reg;
        if (g_reg > mx_next) mx_next = g_reg;
        if (b_reg > mx_next) mx_next = b_reg;
        if (r_reg == mx_next)
        begin
            sec_next = rgbhls_pkg::SEC_RED;
            ab_next  = {1'b0, g_reg} - {1'b0, b_reg};
        end
        else if (g_reg == mx_next)
        begin
            sec_next = rgbhls_pkg::SEC_GREEN;
            ab_next  = {1'b0, b_reg} - {1'b0, r_reg};
        end
        else
        begin
            sec_next = rgbhls_pkg::SEC_BLUE;
            ab_next  = {1'b0, r_reg} - {1'b0, g_reg};
        end
    end

    always_comb
    begin
        diff_s3 = mx_reg - mn_reg;
        sum_s3  = {1'b0, mx_reg} + {1'b0, mn_reg};
        case (sec_reg)
            rgbhls_pkg::SEC_RED:   base_next = BW'(rgbhls_pkg::OFS_RED) * BW'(diff_s3);
            rgbhls_pkg::SEC_GREEN: base_next = BW'(rgbhls_pkg::OFS_GREEN) * BW'(diff_s3);
            default:               base_next = BW'(rgbhls_pkg::OFS_BLUE) * BW'(diff_s3);
        endcase
        // a - b is signed but the sum stays nonnegative; wrap-around adds are exact
        base_next = base_next + BW'({{(BW-CW-1){ab_reg[CW]}}, ab_reg});
    end

    assign prod_s4 = (BW+HSW)'(base_reg) * (BW+HSW)'(HSCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= clamp(red);
            g_reg <= clamp(green);
            b_reg <= clamp(blue);

            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            ab_reg  <= ab_next;
            sec_reg <= sec_next;

            diff_reg   <= diff_s3;
            light3_reg <= CW'((sum_s3 + (CW+1)'(1)) >> 1);
            base_reg   <= base_next;
            grey3_reg  <= (diff_s3 == '0);
            sden_reg   <= (int'(sum_s3) < ONE) ? sum_s3 : (CW+1)'(2 * ONE) - sum_s3;

            hnum_reg   <= (NW'(prod_s4) << 1) + NW'(diff_reg);
            hden_reg   <= DW'(diff_reg) << 1;
            snum_reg   <= (NW'(diff_reg) << (CF + 1)) + NW'(sden_reg);
            sden4_reg  <= DW'(sden_reg) << 1;
            light4_reg <= light3_reg;
            grey4_reg  <= grey3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign hue_num   = hnum_reg;
    assign hue_den   = hden_reg;
    assign sat_num   = snum_reg;
    assign sat_den   = sden4_reg;
    assign light     = light4_reg;
    assign grey      = grey4_reg;

endmodule

// ----- sv/rgbhls_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a tag line.
// Depends on nothing but its parameters.
module rgbhls_div #(
    parameter int NW   = 32,
    parameter int DW   = 15,
    parameter int QW   = 15,
    parameter int TAGW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num,
    input  logic [DW-1:0]   den,
    input  logic [TAGW-1:0] in_tag,
    output logic            out_valid,
    output logic [QW-1:0]   quo,
    output logic [TAGW-1:0] out_tag
);

    logic [QW-1:0]   v_reg;
    logic [DW-1:0]   rem_reg [QW];
    logic [DW-1:0]   den_reg [QW];
    logic [QW-1:0]   nlo_reg [QW];
    logic [QW-1:0]   q_reg   [QW];
    logic [TAGW-1:0] tag_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-2:0], in_valid};
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0]   rem_in, den_in;
        logic [QW-1:0]   nlo_in, q_in;
        logic [TAGW-1:0] tag_in;
        logic [DW:0]     trial;
        logic            fits;

        if (k == 0)
        begin : g_first
            // quotient fits in QW bits, so the high part is already below den
            assign rem_in = DW'(num >> QW);
            assign nlo_in = num[QW-1:0];
            assign den_in = den;
            assign q_in   = '0;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign nlo_in = nlo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign trial = {rem_in, nlo_in[QW-1-k]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? DW'(trial - {1'b0, den_in}) : DW'(trial);
                den_reg[k] <= den_in;
                nlo_reg[k] <= nlo_in;
                q_reg[k]   <= q_in | (QW'(fits) << (QW - 1 - k));
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

// ----- sv/rgb_to_hls_converter_top.sv -----
// RGB to HLS converter, stream in and stream out, one pixel per clock while the
// skid slot is free. Pipeline: 4 front stages, one stage per quotient bit (15 at
// the default sizes), and one output register.
// The divider pipelines set the depth.
// Reset (rst_n, asynchronous, active low) clears all valid bits and the skid.
// Depends on rgbhls_pkg, rgbhls_front and rgbhls_div.
module rgb_to_hls_converter_top #(
    parameter int CHANNEL_FRAC_BITS = rgbhls_pkg::CHANNEL_FRAC_BITS_DEF,
    parameter int HUE_FRAC_BITS     = rgbhls_pkg::HUE_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] red_in, [31:16] green_in, [47:32] blue_in
    input  logic [rgbhls_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [14:0] hue_out, [27:15] lightness_out, [40:28] saturation_out, rest zero
    output logic [rgbhls_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    localparam int CW   = CHANNEL_FRAC_BITS + 1;
    localparam int HSW  = 6 + HUE_FRAC_BITS;
    localparam int HNW  = CW + 3 + HSW;
    localparam int SNW  = CW + CHANNEL_FRAC_BITS;
    localparam int NW   = ((HNW > SNW) ? HNW : SNW) + 2;
    localparam int DW   = CW + 2;
    localparam int HQW  = $clog2((rgbhls_pkg::HUE_MAX_DEG << HUE_FRAC_BITS) + 1);
    localparam int QW   = (CW > HQW) ? CW : HQW;
    localparam int FULL = rgbhls_pkg::HUE_TURN_DEG << HUE_FRAC_BITS;
    localparam int ONE  = 1 << CHANNEL_FRAC_BITS;
    localparam int OUT_W = rgbhls_pkg::HUE_W + 2 * rgbhls_pkg::LS_W;

    // The front and divider stages advance while the skid slot is free.
    logic advance;

    logic          f_valid, f_grey;
    logic [NW-1:0] f_hnum, f_snum;
    logic [DW-1:0] f_hden, f_sden;
    logic [CW-1:0] f_light;

    logic          d_valid, d_valid_sat;
    logic [QW-1:0] hue_q, sat_q;
    logic [CW:0]   hue_tag;
    logic          sat_tag;

    logic [OUT_W-1:0] pipe_word;
    logic [QW-1:0]    hue_wrap;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             skid_full_reg, skid_full_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;

    assign advance       = !skid_full_reg;
    assign s_axis_tready = advance;

    rgbhls_front #(
        .CF (CHANNEL_FRAC_BITS),
        .HF (HUE_FRAC_BITS),
        .CW (CW),
        .NW (NW),
        .DW (DW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_axis_tvalid),
        .red       (s_axis_tdata[15:0]),
        .green     (s_axis_tdata[31:16]),
        .blue      (s_axis_tdata[47:32]),
        .out_valid (f_valid),
        .hue_num   (f_hnum),
        .hue_den   (f_hden),
        .sat_num   (f_snum),
        .sat_den   (f_sden),
        .light     (f_light),
        .grey      (f_grey)
    );

    // Hue quotient carries lightness and the grey flag alongside.
    rgbhls_div #(
        .NW   (NW),
        .DW   (DW),
        .QW   (QW),
        .TAGW (CW + 1)
    ) u_div_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (f_valid),
        .num       (f_hnum),
        .den       (f_hden),
        .in_tag    ({f_grey, f_light}),
        .out_valid (d_valid),
        .quo       (hue_q),
        .out_tag   (hue_tag)
    );

    rgbhls_div #(
        .NW   (NW),
        .DW   (DW),
        .QW   (QW),
        .TAGW (1)
    ) u_div_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (f_valid),
        .num       (f_snum),
        .den       (f_sden),
        .in_tag    (f_grey),
        .out_valid (d_valid_sat),
        .quo       (sat_q),
        .out_tag   (sat_tag)
    );

    // Wrap only hues strictly above a full turn; grey pixels zero hue and saturation.
    assign hue_wrap = (hue_q > QW'(FULL)) ? hue_q - QW'(FULL) : hue_q;

    always_comb
    begin
        pipe_word = '0;
        if (!hue_tag[CW])
        begin
            pipe_word[rgbhls_pkg::HUE_W-1:0] = rgbhls_pkg::HUE_W'(hue_wrap);
            pipe_word[OUT_W-1 -: rgbhls_pkg::LS_W] = rgbhls_pkg::LS_W'(sat_q);
        end
        pipe_word[rgbhls_pkg::HUE_W +: rgbhls_pkg::LS_W] = rgbhls_pkg::LS_W'(hue_tag[CW-1:0]);
    end

    // Output register plus one skid slot: a new pixel is taken while a result waits.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = skid_data_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = advance && d_valid;
                out_data_next  = pipe_word;
            end
        end
        else if (advance && d_valid)
        begin
            skid_full_next = 1'b1;
            skid_data_next = pipe_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rgbhls_pkg::M_DATA_W'(out_data_reg);

    // Both dividers stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid == d_valid_sat) && (!d_valid || hue_tag[CW] == sat_tag))
        else $error("hue and saturation dividers out of step");

    // The skid slot only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a result while the output is empty");

    // Delivered hue never exceeds a full turn; lightness never exceeds one.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (int'(out_data_reg[rgbhls_pkg::HUE_W-1:0]) <= FULL)
            && (int'(out_data_reg[rgbhls_pkg::HUE_W +: rgbhls_pkg::LS_W]) <= ONE))
        else $error("result out of range");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for rgb_to_hls_converter_top: drives pixels on the input
// stream, predicts hue/lightness/saturation per pixel and checks each output transaction.
// Depends on rgbhls_pkg and the converter RTL.
module tb_top;

    localparam int ONE        = 1 << rgbhls_pkg::CHANNEL_FRAC_BITS_DEF;
    localparam int HUE_SCALE  = rgbhls_pkg::HUE_SECTOR_DEG << rgbhls_pkg::HUE_FRAC_BITS_DEF;
    localparam int FULL_TURN  = rgbhls_pkg::HUE_TURN_DEG << rgbhls_pkg::HUE_FRAC_BITS_DEF;
    localparam int LATENCY    = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [rgbhls_pkg::HUE_W-1:0] hue;
        logic [rgbhls_pkg::LS_W-1:0]  light;
        logic [rgbhls_pkg::LS_W-1:0]  sat;
    } hls_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [rgbhls_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [rgbhls_pkg::M_DATA_W-1:0] m_axis_tdata;

    hls_t hls_expected[$];
    int   error_count = 0;
    int   pixels_sent = 0;
    int   results_seen = 0;
    int   cycle_count = 0;
    bit   hold_off_req = 1'b0;    // request a long receiver stall
    bit   hold_off_active = 1'b0;
    bit   sink_random = 1'b1;     // 0: receiver ready unless held off

    always #6 clk = ~clk;

    rgb_to_hls_converter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clamp a raw signed channel to [0, ONE]
    function automatic int clamp_channel(logic [rgbhls_pkg::IN_W-1:0] raw);
        int v;
        v = $signed(raw);
        if (v < 0) v = 0;
        if (v > ONE) v = ONE;
        return v;
    endfunction

    function automatic longint rounded_quotient(longint num, longint den);
        if (den == 0) return 0;
        return (2 * num + den) / (2 * den);
    endfunction

    // Compute the HLS result of one pixel
    function automatic hls_t convert_pixel(logic [rgbhls_pkg::IN_W-1:0] r_raw,
                                           logic [rgbhls_pkg::IN_W-1:0] g_raw,
                                           logic [rgbhls_pkg::IN_W-1:0] b_raw);
        longint r, g, b, mx, mn, diff, sum, base, hue, sat;
        rgbhls_pkg::sector_t sec;
        hls_t res;
        r = clamp_channel(r_raw);
        g = clamp_channel(g_raw);
        b = clamp_channel(b_raw);
        mx = r; mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        diff = mx - mn;
        sum  = mx + mn;
        res.light = rgbhls_pkg::LS_W'((sum + 1) >> 1);
        if (diff == 0)
        begin
            res.hue = '0;
            res.sat = '0;
            return res;
        end
        if (sum < ONE) sat = rounded_quotient(diff * ONE, sum);
        else           sat = rounded_quotient(diff * ONE, 2 * ONE - sum);
        // red wins ties over green, green over blue
        if (r == mx)      sec = rgbhls_pkg::SEC_RED;
        else if (g == mx) sec = rgbhls_pkg::SEC_GREEN;
        else              sec = rgbhls_pkg::SEC_BLUE;
        case (sec)
            rgbhls_pkg::SEC_RED:   base = rgbhls_pkg::OFS_RED * diff + g - b;
            rgbhls_pkg::SEC_GREEN: base = rgbhls_pkg::OFS_GREEN * diff + b - r;
            default:               base = rgbhls_pkg::OFS_BLUE * diff + r - g;
        endcase
        hue = rounded_quotient(HUE_SCALE * base, diff);
        // only values strictly above a full turn wrap
        if (hue > FULL_TURN) hue -= FULL_TURN;
        res.hue = rgbhls_pkg::HUE_W'(hue);
        res.sat = rgbhls_pkg::LS_W'(sat);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(logic [rgbhls_pkg::IN_W-1:0] r, logic [rgbhls_pkg::IN_W-1:0] g,
                              logic [rgbhls_pkg::IN_W-1:0] b, bit with_gap);
        int gap;
        gap = with_gap ? pick_gap() : 0;
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        hls_expected.push_back(convert_pixel(r, g, b));
        pixels_sent++;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (hls_expected.size() != 0) @(posedge clk);
    endtask

    function automatic logic [rgbhls_pkg::IN_W-1:0] random_channel();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return rgbhls_pkg::IN_W'($urandom_range(0, ONE));
        if (p < 80) return rgbhls_pkg::IN_W'($urandom_range(0, 3) * (ONE / 4));
        return rgbhls_pkg::IN_W'($urandom());
    endfunction

    // Extremes of the fields and every special case
    task automatic test_directed();
        send_pixel(16'h0000, 16'h0000, 16'h0000, 0);     // black, grey
        send_pixel(16'h1000, 16'h1000, 16'h1000, 0);     // white, grey
        send_pixel(16'h0800, 16'h0800, 16'h0800, 0);     // mid grey
        send_pixel(16'h1000, 16'h0000, 16'h0000, 0);     // pure red, exactly full turn
        send_pixel(16'h1000, 16'h0400, 16'h0400, 1);     // red sector, green equals blue
        send_pixel(16'h0000, 16'h1000, 16'h0000, 0);     // pure green
        send_pixel(16'h0000, 16'h0000, 16'h1000, 0);     // pure blue
        send_pixel(16'h1000, 16'h1000, 16'h0000, 0);     // red/green tie
        send_pixel(16'h0000, 16'h1000, 16'h1000, 1);     // green/blue tie
        send_pixel(16'h1000, 16'h0000, 16'h1000, 0);     // red/blue tie
        send_pixel(16'h1000, 16'h0000, 16'h0001, 0);     // red sector just below a turn
        send_pixel(16'h1000, 16'h0001, 16'h0000, 0);     // red sector wraps
        send_pixel(16'h8000, 16'h7FFF, 16'hFFFF, 0);     // clamp both ways
        send_pixel(16'h7FFF, 16'h8000, 16'h0001, 1);
        send_pixel(16'hFFFF, 16'h8000, 16'h7FFF, 0);
        send_pixel(16'h5555, 16'hAAAA, 16'h1001, 0);
        send_pixel(16'h0001, 16'h0000, 16'h0000, 0);     // tiny diff, small sum
        send_pixel(16'h1000, 16'h0FFF, 16'h0FFF, 0);     // tiny diff, large sum
        send_pixel(16'h0800, 16'h0000, 16'h0400, 1);     // sum exactly one half
        send_pixel(16'h0C00, 16'h0400, 16'h0800, 0);     // sum exactly one
        send_pixel(16'h0123, 16'h0ABC, 16'h0567, 0);
        go_idle();
        wait_drained();
    endtask

    // Random pixels with random gaps on both sides
    task automatic test_random(int count);
        repeat (count)
            send_pixel(random_channel(), random_channel(), random_channel(), 1);
        go_idle();
    endtask

    // Receiver stalls for a long stretch while pixels keep coming, filling the pipe
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        sink_random = 1'b0;
        repeat (80)
            send_pixel(random_channel(), random_channel(), random_channel(), 0);
        go_idle();
        wait_drained();
        sink_random = 1'b1;
    endtask

    // Back-to-back pixels with the receiver always ready
    task automatic test_full_rate();
        sink_random = 1'b0;
        repeat (60)
            send_pixel(random_channel(), random_channel(), random_channel(), 0);
        go_idle();
        wait_drained();
        sink_random = 1'b1;
    endtask

    // Receiver: random readiness, held off while the long stall runs
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= sink_random ? ($urandom_range(0, 99) < 75) : 1'b1;
    end

    // Count the hold-off in cycles, then release it
    initial
    begin
        wait (hold_off_req);
        @(posedge clk);
        hold_off_active <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off_active <= 1'b0;
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        hls_t got;
        hls_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hue   = m_axis_tdata[14:0];
            got.light = m_axis_tdata[27:15];
            got.sat   = m_axis_tdata[40:28];
            results_seen++;
            if (hls_expected.size() == 0)
            begin
                $display("%0t: unexpected result hue=%0d light=%0d sat=%0d", $time,
                         got.hue, got.light, got.sat);
                error_count++;
            end
            else
            begin
                exp_res = hls_expected.pop_front();
                if (got.hue !== exp_res.hue)
                begin
                    $display("%0t: hue expected %0d actual %0d", $time, exp_res.hue, got.hue);
                    error_count++;
                end
                if (got.light !== exp_res.light)
                begin
                    $display("%0t: lightness expected %0d actual %0d", $time,
                             exp_res.light, got.light);
                    error_count++;
                end
                if (got.sat !== exp_res.sat)
                begin
                    $display("%0t: saturation expected %0d actual %0d", $time,
                             exp_res.sat, got.sat);
                    error_count++;
                end
                if (m_axis_tdata[rgbhls_pkg::M_DATA_W-1:41] !== '0)
                begin
                    $display("%0t: pad bits expected 0 actual %0h", $time,
                             m_axis_tdata[rgbhls_pkg::M_DATA_W-1:41]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on total cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     hls_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        wait_drained();       // sender pauses until every result is back
        test_backpressure();
        test_full_rate();
        test_random(160);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered: %0d pixels (directed corners, random, full rate, long stall)",
                 pixels_sent);
        $display("%0d results checked, %0d errors", results_seen, error_count);
        if (error_count == 0 && hls_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
